@@ hdl/gfbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_pkg: shared types, constants and tables of the glyph frame buffer.
// Holds the microcode format and program, the font table and the command set.
// ----------------------------------------------------------------------------
package gfbr_pkg;

  // Default geometry of the frame store and the glyph cell.
  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int FRAME_BYTES_DEF  = 1024;
  localparam int GLYPH_HEIGHT_DEF = 12;
  localparam int GLYPH_WIDTH      = 8;

  // Width of the linear byte index before range checking.
  localparam int LIN_W   = 16;
  // Glyph row and column counter widths (glyphs are at most 16 rows).
  localparam int ROW_W   = 4;
  localparam int COL_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int ROM_ROWS    = 12;
  localparam int GLYPH_COUNT = 13;
  localparam logic [SLOT_W-1:0] SLOT_SPACE = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_COLON = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_BOX   = 4'd12;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_GLYPH = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Microcode step addresses.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PIX_RD  = 3'd1,
    ST_PIX_WR  = 3'd2,
    ST_FILL    = 3'd3,
    ST_READ    = 3'd4,
    ST_CAPTURE = 3'd5,
    ST_DONE    = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_PIX,
    MEM_WR_PIX,
    MEM_WR_FILL,
    MEM_RD_IDX
  } mem_op_t;

  typedef enum logic [1:0] {
    CTR_NONE,
    CTR_PIX,
    CTR_FILL
  } ctr_op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_DISPATCH,
    BR_LOOP_PIX,
    BR_LOOP_FILL,
    BR_EMIT
  } br_t;

  typedef struct packed {
    mem_op_t mem_op;
    ctr_op_t ctr;
    logic    cap;
    br_t     br;
    step_t   target;
  } uword_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    logic    load;
    mem_op_t mem_op;
    ctr_op_t ctr;
    logic    cap;
  } ctrl_t;

  // Loop conditions reported back by the datapath.
  typedef struct packed {
    logic pix_last;
    logic fill_last;
  } stat_t;

  // The control program. Loops exit to ST_DONE when their condition is met.
  function automatic uword_t ucode(step_t s);
    uword_t u;
    begin
      u = '{mem_op: MEM_NONE, ctr: CTR_NONE, cap: 1'b0, br: BR_NEXT, target: ST_IDLE};
      case (s)
        ST_IDLE:    u.br = BR_DISPATCH;
        ST_PIX_RD:  u.mem_op = MEM_RD_PIX;
        ST_PIX_WR: begin
          u.mem_op = MEM_WR_PIX;
          u.ctr    = CTR_PIX;
          u.br     = BR_LOOP_PIX;
          u.target = ST_PIX_RD;
        end
        ST_FILL: begin
          u.mem_op = MEM_WR_FILL;
          u.ctr    = CTR_FILL;
          u.br     = BR_LOOP_FILL;
          u.target = ST_FILL;
        end
        ST_READ:    u.mem_op = MEM_RD_IDX;
        ST_CAPTURE: u.cap = 1'b1;
        ST_DONE: begin
          u.br     = BR_EMIT;
          u.target = ST_IDLE;
        end
        default: u.target = ST_IDLE;
      endcase
      return u;
    end
  endfunction

  // First step of each command's routine.
  function automatic step_t entry_of(cmd_t c);
    step_t s;
    begin
      case (c)
        CMD_PIXEL: s = ST_PIX_RD;
        CMD_GLYPH: s = ST_PIX_RD;
        CMD_FILL:  s = ST_FILL;
        CMD_READ:  s = ST_READ;
        default:   s = ST_IDLE;
      endcase
      return s;
    end
  endfunction

  localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT-1][0:ROM_ROWS-1] = '{
    '{8'h3C, 8'h66, 8'h42, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h42, 8'h66, 8'h3C},
    '{8'h0C, 8'h3C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h3F},
    '{8'h1E, 8'h27, 8'h43, 8'h03, 8'h03, 8'h02, 8'h06, 8'h04, 8'h08, 8'h10, 8'h3F, 8'h7F},
    '{8'h1E, 8'h67, 8'h43, 8'h03, 8'h06, 8'h0E, 8'h07, 8'h03, 8'h03, 8'h03, 8'h66, 8'h7C},
    '{8'h06, 8'h06, 8'h0E, 8'h16, 8'h26, 8'h26, 8'h46, 8'h86, 8'hFF, 8'h06, 8'h06, 8'h06},
    '{8'h1E, 8'h1E, 8'h20, 8'h38, 8'h7C, 8'h0E, 8'h06, 8'h02, 8'h02, 8'h02, 8'h44, 8'h78},
    '{8'h07, 8'h1C, 8'h30, 8'h60, 8'h5C, 8'hE6, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h66, 8'h3C},
    '{8'h7F, 8'h7F, 8'h81, 8'h02, 8'h02, 8'h02, 8'h04, 8'h04, 8'h08, 8'h08, 8'h08, 8'h10},
    '{8'h3C, 8'h62, 8'hC3, 8'hC3, 8'h66, 8'h38, 8'h3C, 8'h46, 8'hC3, 8'hC3, 8'h62, 8'h3C},
    '{8'h3C, 8'h66, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h63, 8'h3E, 8'h06, 8'h0C, 8'h18, 8'hE0},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h18, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h18, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
  };

  function automatic logic [SLOT_W-1:0] glyph_slot(logic [7:0] code);
    logic [7:0] d;
    logic [SLOT_W-1:0] s;
    begin
      d = code - 8'h30;
      if (code inside {[8'h30:8'h39]}) s = d[SLOT_W-1:0];
      else if (code == 8'h20)          s = SLOT_SPACE;
      else if (code == 8'h3A)          s = SLOT_COLON;
      else                             s = SLOT_BOX;
      return s;
    end
  endfunction

  // Rows below the stored ones read as dark.
  function automatic logic [7:0] glyph_bits(logic [SLOT_W-1:0] slot, logic [ROW_W-1:0] row);
    logic [7:0] b;
    begin
      if (row >= ROW_W'(ROM_ROWS) || slot >= SLOT_W'(GLYPH_COUNT)) b = 8'h00;
      else                                                          b = FONT_ROM[slot][row];
      return b;
    end
  endfunction

endpackage

@@ hdl/gfbr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_ram: single-port frame store memory.
// One access per cycle, write or registered read.
// ----------------------------------------------------------------------------
module gfbr_ram #(
  parameter int DEPTH  = gfbr_pkg::FRAME_BYTES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata_r
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

@@ hdl/gfbr_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_seq: microcode sequencer.
// Step counter, control store lookup and branch decision.
// ----------------------------------------------------------------------------
module gfbr_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  gfbr_pkg::cmd_t   in_cmd,
  input  gfbr_pkg::stat_t  stat,
  input  logic             out_free,
  output logic             in_ready,
  output logic             emit,
  output gfbr_pkg::ctrl_t  ctrl,
  output gfbr_pkg::step_t  step
);

  gfbr_pkg::step_t  step_r, step_nxt;
  gfbr_pkg::uword_t uw;
  logic             owed_r, owed_nxt;

  // Reset enters the fill loop so that the store is swept to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= gfbr_pkg::ST_FILL;
      owed_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      owed_r <= owed_nxt;
    end
  end

  always_comb begin
    uw          = gfbr_pkg::ucode(step_r);
    in_ready    = (uw.br == gfbr_pkg::BR_DISPATCH);
    emit        = 1'b0;
    step_nxt    = step_r;
    owed_nxt    = owed_r;
    ctrl.load   = 1'b0;
    ctrl.mem_op = uw.mem_op;
    ctrl.ctr    = uw.ctr;
    ctrl.cap    = uw.cap;
    case (uw.br)
      gfbr_pkg::BR_NEXT:      step_nxt = gfbr_pkg::step_t'(3'(step_r) + 3'd1);
      gfbr_pkg::BR_DISPATCH: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          owed_nxt  = 1'b1;
          step_nxt  = gfbr_pkg::entry_of(in_cmd);
        end
      end
      gfbr_pkg::BR_LOOP_PIX:  step_nxt = stat.pix_last ? gfbr_pkg::ST_DONE : uw.target;
      gfbr_pkg::BR_LOOP_FILL: step_nxt = stat.fill_last ? gfbr_pkg::ST_DONE : uw.target;
      gfbr_pkg::BR_EMIT: begin
        if (!owed_r) begin
          step_nxt = uw.target;
        end else if (out_free) begin
          emit     = 1'b1;
          owed_nxt = 1'b0;
          step_nxt = uw.target;
        end
      end
      default: step_nxt = gfbr_pkg::ST_IDLE;
    endcase
  end

  assign step = step_r;

endmodule

@@ hdl/gfbr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_dpath: frame store datapath.
// Command latches, glyph and fill counters, address generation and memory.
// ----------------------------------------------------------------------------
module gfbr_dpath #(
  parameter int SCREEN_WIDTH = gfbr_pkg::SCREEN_WIDTH_DEF,
  parameter int FRAME_BYTES  = gfbr_pkg::FRAME_BYTES_DEF,
  parameter int GLYPH_HEIGHT = gfbr_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gfbr_pkg::ctrl_t  ctrl,
  input  gfbr_pkg::cmd_t   in_cmd,
  input  logic [6:0]       in_x,
  input  logic [5:0]       in_y,
  input  logic             in_colour,
  input  logic [7:0]       in_code,
  input  logic [9:0]       in_index,
  output gfbr_pkg::stat_t  stat,
  output logic [7:0]       result
);

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int LIN_W  = gfbr_pkg::LIN_W;

  gfbr_pkg::cmd_t                cmd_r;
  logic [6:0]                    x_r;
  logic [5:0]                    y_r;
  logic                          colour_r;
  logic [gfbr_pkg::SLOT_W-1:0]   slot_r;
  logic [9:0]                    index_r;
  logic [gfbr_pkg::ROW_W-1:0]    row_r;
  logic [gfbr_pkg::COL_W-1:0]    col_r;
  logic [ADDR_W-1:0]             fill_addr_r;
  logic [7:0]                    result_r;

  logic [7:0]        px;
  logic [6:0]        py;
  logic [LIN_W-1:0]  lin;
  logic [LIN_W-1:0]  ridx;
  logic              on_screen;
  logic              idx_ok;
  logic [7:0]        bits;
  logic              lit;
  logic [7:0]        mask;
  logic [7:0]        rdata;
  logic [7:0]        pix_wdata;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        wdata;

  // Fill address and colour reset so the post-reset sweep writes zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_addr_r <= '0;
      colour_r    <= 1'b0;
    end else if (ctrl.load) begin
      fill_addr_r <= '0;
      colour_r    <= in_colour;
    end else if (ctrl.ctr == gfbr_pkg::CTR_FILL) begin
      fill_addr_r <= fill_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= in_cmd;
      x_r      <= in_x;
      y_r      <= in_y;
      slot_r   <= gfbr_pkg::glyph_slot(in_code);
      index_r  <= in_index;
      row_r    <= '0;
      col_r    <= '0;
      result_r <= 8'h00;
    end else begin
      if (ctrl.ctr == gfbr_pkg::CTR_PIX) begin
        col_r <= col_r + 1'b1;
        if (col_r == gfbr_pkg::COL_W'(gfbr_pkg::GLYPH_WIDTH - 1)) begin
          row_r <= row_r + 1'b1;
        end
      end
      if (ctrl.cap) begin
        result_r <= idx_ok ? rdata : 8'h00;
      end
    end
  end

  always_comb begin
    px        = {1'b0, x_r} + 8'(col_r);
    py        = {1'b0, y_r} + 7'(row_r);
    lin       = LIN_W'(py[6:3]) * LIN_W'(SCREEN_WIDTH) + LIN_W'(px);
    on_screen = (LIN_W'(px) < LIN_W'(SCREEN_WIDTH)) && (lin < LIN_W'(FRAME_BYTES));
    ridx      = LIN_W'(index_r);
    idx_ok    = ridx < LIN_W'(FRAME_BYTES);
    bits      = gfbr_pkg::glyph_bits(slot_r, row_r);
    lit       = (cmd_r == gfbr_pkg::CMD_PIXEL) ? colour_r
              : bits[gfbr_pkg::COL_W'(gfbr_pkg::GLYPH_WIDTH - 1) - col_r];
    mask      = 8'h01 << py[2:0];
    pix_wdata = lit ? (rdata | mask) : (rdata & ~mask);
    stat.pix_last  = (cmd_r == gfbr_pkg::CMD_PIXEL) ||
                     ((col_r == gfbr_pkg::COL_W'(gfbr_pkg::GLYPH_WIDTH - 1)) &&
                      (row_r == gfbr_pkg::ROW_W'(GLYPH_HEIGHT - 1)));
    stat.fill_last = (fill_addr_r == ADDR_W'(FRAME_BYTES - 1));
    we    = 1'b0;
    re    = 1'b0;
    addr  = lin[ADDR_W-1:0];
    wdata = pix_wdata;
    case (ctrl.mem_op)
      gfbr_pkg::MEM_RD_PIX:  re = 1'b1;
      gfbr_pkg::MEM_WR_PIX:  we = on_screen;
      gfbr_pkg::MEM_WR_FILL: begin
        we    = 1'b1;
        addr  = fill_addr_r;
        wdata = {8{colour_r}};
      end
      gfbr_pkg::MEM_RD_IDX: begin
        re   = idx_ok;
        addr = ridx[ADDR_W-1:0];
      end
      default: re = 1'b0;
    endcase
  end

  gfbr_ram #(
    .DEPTH  (FRAME_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .re      (re),
    .addr    (addr),
    .wdata   (wdata),
    .rdata_r (rdata)
  );

  assign result = result_r;

endmodule

@@ hdl/glyph_frame_buffer_renderer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_frame_buffer_renderer_core: page-mode monochrome frame buffer.
// Pixel writes, clipped 8-wide glyph draws, whole-store fills and byte reads.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Words
//  in_      slave      in_tvalid/in_tready  one command word each
//  out_     master     out_tvalid/out_tready one result byte per command
//
//  A pixel write is one read-modify-write of a byte and a byte read is one read
//  and capture. A glyph draw walks all 8 * GLYPH_HEIGHT glyph pixels, because every
//  glyph pixel is a read-modify-write on the single memory port. A fill writes
//  across the whole store, one byte written per cycle.
//  After reset a clearing pass zeroes the store while in_tready stays low. A stalled
//  result waits in the output register; the next command is taken meanwhile and
//  only its own final step waits for room.
//
module glyph_frame_buffer_renderer_core #(
  parameter int SCREEN_WIDTH = gfbr_pkg::SCREEN_WIDTH_DEF,
  parameter int FRAME_BYTES  = gfbr_pkg::FRAME_BYTES_DEF,
  parameter int GLYPH_HEIGHT = gfbr_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_x[6:0], pixel_y[12:7], colour[13], char_code[21:14], read_index[31:22]
  input  logic [31:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  output logic [7:0]  out_tdata
);

  gfbr_pkg::ctrl_t ctrl;
  gfbr_pkg::stat_t stat;
  gfbr_pkg::step_t step;
  gfbr_pkg::cmd_t  in_cmd;
  logic            emit;
  logic            out_free;
  logic [7:0]      result;
  logic            out_tvalid_r;
  logic [7:0]      out_tdata_r;

  assign in_cmd   = gfbr_pkg::cmd_t'(in_tuser);
  // The output register can take a new byte when empty or being drained.
  assign out_free = !out_tvalid_r || out_tready;

  gfbr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .out_free (out_free),
    .in_ready (in_tready),
    .emit     (emit),
    .ctrl     (ctrl),
    .step     (step)
  );

  gfbr_dpath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .FRAME_BYTES  (FRAME_BYTES),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_cmd    (in_cmd),
    .in_x      (in_tdata[6:0]),
    .in_y      (in_tdata[12:7]),
    .in_colour (in_tdata[13]),
    .in_code   (in_tdata[21:14]),
    .in_index  (in_tdata[31:22]),
    .stat      (stat),
    .result    (result)
  );

  // Output register: loaded when the sequencer finishes a command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted word always moves the sequencer out of its dispatch step.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer stayed in dispatch after accepting a word");

  // A result is only loaded when the output register has room for it.
  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded over an undelivered byte");

  // The fill loop either continues or finishes; it never jumps elsewhere.
  a_fill_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (step == gfbr_pkg::ST_FILL) |=>
      (step == gfbr_pkg::ST_FILL || step == gfbr_pkg::ST_DONE))
    else $error("fill loop left to an unexpected step");

  // Commands are taken only from the dispatch step.
  a_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> (step == gfbr_pkg::ST_IDLE && in_tvalid))
    else $error("command latched outside the dispatch step");

endmodule
